// ===== design/cdem_pkg.sv =====
// shared types, constants and month tables for the civil date to epoch ms pipeline
package cdem_pkg;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  localparam int EraW  = 21;  // era count for years within the limit
  localparam int DaysW = 38;  // signed day count
  localparam int SecsW = 55;  // signed seconds count
  localparam int TodW  = 17;  // seconds within a day

  localparam logic signed [31:0] YearLimit = 32'sd300000000;

  // floor(year / 400) via (year + 2^31) >> 4, then times ceil(2^33 / 25)
  localparam logic [28:0] Recip25    = 29'd343597384;
  localparam int          Recip25Sh  = 33;
  // 2^31 = 400 * EraBias + BiasMod400
  localparam logic signed [24:0] EraBias    = 25'sd5368709;
  localparam logic [8:0]         BiasMod400 = 9'd48;
  localparam logic [8:0]         Mod400Fix  = 9'd352;

  localparam logic [17:0] DaysPerYear = 18'd365;
  localparam logic signed [DaysW-1:0] DaysPerEra     = 38'sd146097;
  localparam logic signed [DaysW-1:0] EpochShiftDays = 38'sd719468;
  localparam logic signed [SecsW-1:0] SecsPerDay     = 55'sd86400;
  localparam logic [TodW-1:0]         SecsPerHour    = 17'd3600;
  localparam logic [TodW-1:0]         SecsPerMinute  = 17'd60;
  // int64 limits divided by 1000, truncated
  localparam logic signed [SecsW-1:0] SecHigh = 55'sd9223372036854775;

  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam logic [5:0] SecondMax = 6'd59;

  typedef struct packed {
    logic                   valid;
    status_e                status;
    logic signed [EraW-1:0] era;
    logic [8:0]             yoe;
    logic [8:0]             doy;
    logic [TodW-1:0]        tod;
  } front_t;

  typedef struct packed {
    logic                    valid;
    status_e                 status;
    logic signed [SecsW-1:0] secs;
  } secs_t;

  // longest month, february counted with 29 days, zero for a bad month
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd29;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // first day of the month within a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] ofs;
    unique case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== design/cdem_front.sv =====
// front stages: component checks, year split into era and year of era
module cdem_front import cdem_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  output front_t             front_o
);

  // stage 1
  logic [31:0]     ybias;
  logic [56:0]     prod;
  logic            v1_d, v1_q;
  logic [23:0]     q1_d, q1_q;
  logic [8:0]      y9_d, y9_q;
  logic            ok1_d, ok1_q;
  logic            feb29_d, feb29_q;
  logic            rng1_d, rng1_q;
  logic            mle2_d, mle2_q;
  logic [8:0]      doy1_d, doy1_q;
  logic [TodW-1:0] tod1_d, tod1_q;

  assign ybias = {~year_i[31], year_i[30:0]};
  assign prod  = 57'(ybias[31:4]) * 57'(Recip25);
  assign q1_d  = prod[56:Recip25Sh];
  assign y9_d  = ybias[8:0];
  assign v1_d  = start_i;

  assign ok1_d = (month_i != 4'd0) && (day_i != 5'd0) && (day_i <= month_days(month_i)) &&
                 (hour_i <= HourMax) && (minute_i <= MinuteMax) && (second_i <= SecondMax);
  assign feb29_d = (month_i == 4'd2) && (day_i == 5'd29);
  assign rng1_d  = (year_i > YearLimit) || (year_i < -YearLimit);
  assign mle2_d  = (month_i <= 4'd2);
  assign doy1_d  = month_start(month_i) + 9'(day_i) - 9'd1;
  assign tod1_d  = TodW'(hour_i) * SecsPerHour + TodW'(minute_i) * SecsPerMinute +
                   TodW'(second_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q    <= q1_d;
    y9_q    <= y9_d;
    ok1_q   <= ok1_d;
    feb29_q <= feb29_d;
    rng1_q  <= rng1_d;
    mle2_q  <= mle2_d;
    doy1_q  <= doy1_d;
    tod1_q  <= tod1_d;
  end

  // stage 2
  logic [8:0]         r9;
  logic               lt_bias;
  logic [8:0]         ym;
  logic               leap;
  logic signed [24:0] era_y;
  logic signed [24:0] era_a;
  logic [8:0]         yoe;
  status_e            st2;
  front_t             front_d, front_q;

  // remainder of biased year by 400 only needs the low nine bits
  assign r9      = y9_q - 9'(18'(q1_q[8:0]) * 18'd400);
  assign lt_bias = (r9 < BiasMod400);
  assign ym      = lt_bias ? r9 + Mod400Fix : r9 - BiasMod400;
  assign leap    = (ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  assign era_y   = $signed({1'b0, q1_q}) - EraBias - $signed(25'(lt_bias));

  // january and february belong to the previous march-based year
  always_comb begin
    era_a = era_y;
    yoe   = ym;
    if (mle2_q) begin
      if (ym == 9'd0) begin
        era_a = era_y - 25'sd1;
        yoe   = 9'd399;
      end else begin
        yoe = ym - 9'd1;
      end
    end
  end

  always_comb begin
    if (!ok1_q || (feb29_q && !leap)) begin
      st2 = STATUS_INVALID;
    end else if (rng1_q) begin
      st2 = STATUS_RANGE;
    end else begin
      st2 = STATUS_OK;
    end
  end

  always_comb begin
    front_d.valid  = v1_q;
    front_d.status = st2;
    front_d.era    = era_a[EraW-1:0];
    front_d.yoe    = yoe;
    front_d.doy    = doy1_q;
    front_d.tod    = tod1_q;
  end

  // only the valid bit is cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q.valid <= 1'b0;
    end else begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ===== design/cdem_days.sv =====
// day count and seconds stages
module cdem_days import cdem_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  front_t front_i,
  output secs_t  secs_o
);

  // stage 3: days since the epoch
  logic [1:0]              c100;
  logic [17:0]             doe;
  logic signed [DaysW-1:0] days_d, days_q;
  logic                    v3_q;
  status_e                 st3_q;
  logic [TodW-1:0]         tod3_q;

  always_comb begin
    if (front_i.yoe >= 9'd300) begin
      c100 = 2'd3;
    end else if (front_i.yoe >= 9'd200) begin
      c100 = 2'd2;
    end else if (front_i.yoe >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
  end

  assign doe    = 18'(front_i.yoe) * DaysPerYear + 18'(front_i.yoe[8:2]) - 18'(c100) +
                  18'(front_i.doy);
  assign days_d = DaysW'($signed(front_i.era)) * DaysPerEra +
                  DaysW'($signed({1'b0, doe})) - EpochShiftDays;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= front_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    st3_q  <= front_i.status;
    tod3_q <= front_i.tod;
  end

  // stage 4: seconds since the epoch
  secs_t secs_d, secs_q;

  always_comb begin
    secs_d.valid  = v3_q;
    secs_d.status = st3_q;
    secs_d.secs   = SecsW'(days_q) * SecsPerDay + SecsW'($signed({1'b0, tod3_q}));
  end

  // only the valid bit is cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secs_q.valid <= 1'b0;
    end else begin
      secs_q <= secs_d;
    end
  end

  assign secs_o = secs_q;

endmodule

// ===== design/civil_date_to_epoch_ms.sv =====
// top level: proleptic gregorian utc date and time to unix epoch milliseconds
//
// a transaction is taken at every rising edge with start_i high; busy_o stays
// low, so a new date may be presented in every cycle
// inputs: signed astronomical year, month, day, hour, minute, second
// each transaction gives exactly one result, shown for one cycle with valid_o
// high: status_o (ok, invalid component, out of range) and epoch_ms_o, which
// is zero unless status is ok
// throughput is one date per cycle
// the five register stages are: reciprocal divide of the year by 400 and
// component checks, era split and leap test, era times 146097 day count,
// days times 86400 seconds count, range check and times 1000 scaling
// results leave in transaction order; the receiver cannot stall, so nothing
// ever waits inside the pipeline
// reset clears the valid bits of all stages; data registers are not reset
module civil_date_to_epoch_ms import cdem_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic signed [63:0] epoch_ms_o
);

  front_t front;
  secs_t  secs;

  // the pipeline advances every cycle, so it never holds off a new date
  assign busy_o = 1'b0;

  // stages 1 and 2
  cdem_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .year_i   (year_i),
    .month_i  (month_i),
    .day_i    (day_i),
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .second_i (second_i),
    .front_o  (front)
  );

  // stages 3 and 4
  cdem_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .secs_o  (secs)
  );

  // stage 5: seconds range check against the int64 millisecond limits
  logic                    oor;
  status_e                 status_d, status_q;
  logic signed [63:0]      ms_d, ms_q;
  logic                    valid_q;

  assign oor = ($signed(secs.secs) > SecHigh) || ($signed(secs.secs) < -SecHigh);

  always_comb begin
    if (secs.status != STATUS_OK) begin
      status_d = secs.status;
    end else if (oor) begin
      status_d = STATUS_RANGE;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // failed items carry zero milliseconds
  assign ms_d = (status_d == STATUS_OK) ? 64'($signed(secs.secs)) * 64'sd1000 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= secs.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ms_q     <= ms_d;
  end

  assign valid_o    = valid_q;
  assign status_o   = status_q;
  assign epoch_ms_o = ms_q;

`ifndef NO_ASSERTIONS
  // every accepted date comes out as a result on valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##5 valid_o)
    else $error("result missing five cycles after start");

  // no result without a matching accepted transaction
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 5))
    else $error("result without matching transaction");

  // a failed conversion never leaks a partial millisecond value
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != STATUS_OK) |-> (epoch_ms_o == 64'sd0))
    else $error("nonzero epoch_ms on failed status");
`endif

endmodule
